// ===== hdl/nce_pkg.sv =====
`timescale 1ns / 1ps

package nce_pkg;

  // Default build parameters
  localparam int unsigned MAX_RANK_DEF   = 4;
  localparam int unsigned COORD_BITS_DEF = 16;

  // Fixed field widths
  localparam int unsigned NUM_SIZE_REGS = 4;
  localparam int unsigned RANK_W        = 3;
  localparam int unsigned SIZE_W        = 17;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 17;
  localparam int unsigned COORD_W       = 16;
  localparam int unsigned AXIS_W        = 2;
  localparam int unsigned HIT_W         = 32;

  // Tuple queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANK       = 3'd0,
    REG_SIZE_AXIS0 = 3'd1,
    REG_SIZE_AXIS1 = 3'd2,
    REG_SIZE_AXIS2 = 3'd3,
    REG_SIZE_AXIS3 = 3'd4
  } reg_idx_e;

  typedef logic [NUM_SIZE_REGS-1:0][SIZE_W-1:0] size_arr_t;

endpackage

// ===== hdl/nce_front.sv =====
`timescale 1ns / 1ps

module nce_front #(
  parameter int unsigned MAX_RANK   = nce_pkg::MAX_RANK_DEF,
  parameter int unsigned COORD_BITS = nce_pkg::COORD_BITS_DEF,
  localparam int unsigned IDX_W     = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1,
  localparam int unsigned TUPLE_W   = nce_pkg::HIT_W + MAX_RANK * COORD_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    mask_bit_i,
  input  logic [IDX_W-1:0]        last_idx_i,
  input  nce_pkg::size_arr_t      sizes_i,
  input  logic                    queue_full_i,
  output logic                    push_o,
  output logic [TUPLE_W-1:0]      push_data_o
);
  import nce_pkg::*;

  localparam int unsigned LIM_W = (COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W;
  localparam logic [LIM_W-1:0] COORD_MAX = LIM_W'((64'd1 << COORD_BITS) - 64'd1);

  logic [COORD_BITS-1:0] pos_q [MAX_RANK];
  logic [COORD_BITS-1:0] pos_d [MAX_RANK];
  logic [HIT_W-1:0]      cnt_q, cnt_d;
  logic [MAX_RANK-1:0]   at_lim;
  logic [MAX_RANK-1:0]   carry_in;
  logic                  accept;
  logic                  tensor_end;

  assign in_ready_o = ~queue_full_i;
  assign accept     = in_valid_i & in_ready_o;

  // Per-axis wrap detect against extent - 1, clamped to the coordinate range
  for (genvar ax = 0; ax < MAX_RANK; ax++) begin : g_axis
    if (ax < NUM_SIZE_REGS) begin : g_sized
      logic [SIZE_W-1:0] ext;
      logic [LIM_W-1:0]  lim;
      always_comb begin
        ext = (sizes_i[ax] == '0) ? SIZE_W'(1) : sizes_i[ax];
        lim = LIM_W'(ext - SIZE_W'(1));
        if (lim > COORD_MAX) begin
          lim = COORD_MAX;
        end
      end
      assign at_lim[ax] = (LIM_W'(pos_q[ax]) >= lim);
    end else begin : g_unit
      // no size register: extent of one
      assign at_lim[ax] = 1'b1;
    end
  end

  // Carry ripples from the innermost active axis outward
  always_comb begin
    logic c;
    c = 1'b0;
    for (int ax = int'(MAX_RANK) - 1; ax >= 0; ax--) begin
      if (IDX_W'(ax) == last_idx_i) begin
        c = 1'b1;
      end
      carry_in[ax] = c;
      c = c & at_lim[ax];
    end
  end

  assign tensor_end = carry_in[0] & at_lim[0];

  // Next counter values
  always_comb begin
    for (int ax = 0; ax < int'(MAX_RANK); ax++) begin
      pos_d[ax] = pos_q[ax];
      if (accept && carry_in[ax]) begin
        pos_d[ax] = at_lim[ax] ? '0 : pos_q[ax] + 1'b1;
      end
    end
    cnt_d = cnt_q;
    if (accept) begin
      cnt_d = tensor_end ? '0 : cnt_q + HIT_W'(mask_bit_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int ax = 0; ax < int'(MAX_RANK); ax++) begin
        pos_q[ax] <= '0;
      end
      cnt_q <= '0;
    end else begin
      pos_q <= pos_d;
      cnt_q <= cnt_d;
    end
  end

  // Tuple for the queue: hit number on top, axis 0 in the low slice
  always_comb begin
    push_data_o = '0;
    push_data_o[TUPLE_W-1 -: HIT_W] = cnt_q;
    for (int ax = 0; ax < int'(MAX_RANK); ax++) begin
      push_data_o[ax*COORD_BITS +: COORD_BITS] = pos_q[ax];
    end
  end

  assign push_o = accept & mask_bit_i;

endmodule

// ===== hdl/nce_fifo.sv =====
`timescale 1ns / 1ps

module nce_fifo #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = nce_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o
);
  import nce_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_q] <= data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/nce_back.sv =====
`timescale 1ns / 1ps

module nce_back #(
  parameter int unsigned MAX_RANK   = nce_pkg::MAX_RANK_DEF,
  parameter int unsigned COORD_BITS = nce_pkg::COORD_BITS_DEF,
  localparam int unsigned IDX_W     = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1,
  localparam int unsigned TUPLE_W   = nce_pkg::HIT_W + MAX_RANK * COORD_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          head_valid_i,
  input  logic [TUPLE_W-1:0]            head_data_i,
  output logic                          pop_o,
  input  logic [IDX_W-1:0]              last_idx_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [nce_pkg::COORD_W-1:0]   coord_o,
  output logic [nce_pkg::AXIS_W-1:0]    axis_o,
  output logic [nce_pkg::HIT_W-1:0]     hit_number_o,
  output logic                          last_axis_o
);
  import nce_pkg::*;

  logic                  out_valid_q;
  logic [IDX_W-1:0]      idx_q;
  logic [COORD_W-1:0]    coord_q;
  logic [AXIS_W-1:0]     axis_q;
  logic [HIT_W-1:0]      hit_q;
  logic                  last_q;
  logic                  load;
  logic                  is_last;
  logic [COORD_BITS-1:0] sel_coord;

  assign load      = head_valid_i & (~out_valid_q | out_ready_i);
  assign is_last   = (idx_q == last_idx_i);
  assign sel_coord = head_data_i[idx_q*COORD_BITS +: COORD_BITS];
  assign pop_o     = load & is_last;

  // Output valid and axis walk over the head tuple
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= is_last ? '0 : idx_q + 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      coord_q <= COORD_W'(sel_coord);
      axis_q  <= AXIS_W'(idx_q);
      hit_q   <= head_data_i[TUPLE_W-1 -: HIT_W];
      last_q  <= is_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign coord_o      = coord_q;
  assign axis_o       = axis_q;
  assign hit_number_o = hit_q;
  assign last_axis_o  = last_q;

endmodule

// ===== hdl/nonzero_coordinate_emitter.sv =====
`timescale 1ns / 1ps
// Nonzero coordinate emitter: streams the coordinates of the true elements
// of a boolean mask, fed one element per transaction in row-major order.
// Input channel: in_valid_i / in_ready_o with mask_bit_i. Output channel:
// out_valid_o / out_ready_i with coord_o, axis_o, hit_number_o and
// last_axis_o; each true element yields one transaction per axis,
// outermost first, the innermost flagged by last_axis_o.
// Configuration channel: cfg_valid_i / cfg_ready_o (always ready) with
// cfg_index_i and cfg_data_i; write only while the block is idle.
// Throughput: one mask element per cycle while the tuple queue has room;
// the emitter drains one coordinate per cycle while the receiver is ready,
// and each true element of a rank-r tensor takes r coordinate transactions.
// An accepted true element's tuple is written into the queue and then
// loaded, one coordinate at a time, into the output register.
// A stalled receiver holds the output register; the queue (QUEUE_DEPTH
// tuples) keeps taking elements until it fills, then in_ready_o drops.
// Reset clears the position counters, the hit count and the queue, and
// sets rank and all extents to one.
module nonzero_coordinate_emitter #(
  parameter int unsigned MAX_RANK   = nce_pkg::MAX_RANK_DEF,
  parameter int unsigned COORD_BITS = nce_pkg::COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [nce_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [nce_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           mask_bit_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [nce_pkg::COORD_W-1:0]    coord_o,
  output logic [nce_pkg::AXIS_W-1:0]     axis_o,
  output logic [nce_pkg::HIT_W-1:0]      hit_number_o,
  output logic                           last_axis_o
);
  import nce_pkg::*;

  localparam int unsigned IDX_W   = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int unsigned TUPLE_W = HIT_W + MAX_RANK * COORD_BITS;

  logic [RANK_W-1:0]  rank_q;
  size_arr_t          size_q;
  logic [3:0]         rank_eff;
  logic [IDX_W-1:0]   last_idx;
  logic               q_push, q_full, q_pop, q_valid;
  logic [TUPLE_W-1:0] q_wdata, q_rdata;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= RANK_W'(1);
      for (int i = 0; i < int'(NUM_SIZE_REGS); i++) begin
        size_q[i] <= SIZE_W'(1);
      end
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_RANK:       rank_q    <= cfg_data_i[RANK_W-1:0];
        REG_SIZE_AXIS0: size_q[0] <= cfg_data_i[SIZE_W-1:0];
        REG_SIZE_AXIS1: size_q[1] <= cfg_data_i[SIZE_W-1:0];
        REG_SIZE_AXIS2: size_q[2] <= cfg_data_i[SIZE_W-1:0];
        REG_SIZE_AXIS3: size_q[3] <= cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective rank: zero means one, clamp to MAX_RANK
  always_comb begin
    rank_eff = {1'b0, rank_q};
    if (rank_q == '0) begin
      rank_eff = 4'd1;
    end
    if (rank_eff > 4'(MAX_RANK)) begin
      rank_eff = 4'(MAX_RANK);
    end
  end

  assign last_idx = IDX_W'(rank_eff - 4'd1);

  nce_front #(
    .MAX_RANK   (MAX_RANK),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mask_bit_i   (mask_bit_i),
    .last_idx_i   (last_idx),
    .sizes_i      (size_q),
    .queue_full_i (q_full),
    .push_o       (q_push),
    .push_data_o  (q_wdata)
  );

  nce_fifo #(
    .DATA_W (TUPLE_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  nce_back #(
    .MAX_RANK   (MAX_RANK),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_data_i  (q_rdata),
    .pop_o        (q_pop),
    .last_idx_i   (last_idx),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .coord_o      (coord_o),
    .axis_o       (axis_o),
    .hit_number_o (hit_number_o),
    .last_axis_o  (last_axis_o)
  );

endmodule

// ===== hdl/nce_checker.sv =====
`timescale 1ns / 1ps

module nce_assertions (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [nce_pkg::COORD_W-1:0]  coord_o,
  input logic [nce_pkg::AXIS_W-1:0]   axis_o,
  input logic [nce_pkg::HIT_W-1:0]    hit_number_o,
  input logic                         last_axis_o
);
  import nce_pkg::*;

  // A pending result transaction is held
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(coord_o) && $stable(axis_o) && $stable(hit_number_o) && $stable(last_axis_o))
    else $error("output payload changed while stalled");

  // Inside a tuple the next axis follows at once with the same hit number
  a_tuple_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_axis_o |=>
      out_valid_o && (axis_o == AXIS_W'($past(axis_o) + 2'd1)) &&
      (hit_number_o == $past(hit_number_o)))
    else $error("tuple did not continue on the next axis");

  // A new tuple starts on the outermost axis
  a_tuple_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_axis_o) ##1 out_valid_o |-> (axis_o == '0))
    else $error("tuple did not start at axis zero");

endmodule

bind nonzero_coordinate_emitter nce_assertions u_nce_assertions (.*);

// ===== tb/nce_checker.sv =====
`timescale 1ns / 1ps

// Watches the configuration, mask and coordinate channels. Keeps its own copy
// of the extents and axis counters, predicts the coordinate tuple of every
// accepted true element and compares each coordinate transaction in order.
module nce_checker
  import nce_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic                  mask_bit_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [COORD_W-1:0]    coord_i,
  input  logic [AXIS_W-1:0]     axis_i,
  input  logic [HIT_W-1:0]      hit_number_i,
  input  logic                  last_axis_i,
  output int                    mismatches_o,
  output int                    pending_o
);

  localparam int unsigned          MAX_AXES   = MAX_RANK_DEF;
  localparam logic [SIZE_W-1:0]    EXTENT_CAP = 1 << COORD_BITS_DEF;

  typedef struct packed {
    logic [COORD_W-1:0] coord;
    logic [AXIS_W-1:0]  axis;
    logic [HIT_W-1:0]   hit;
    logic               last;
  } coord_beat_t;

  // Shadow configuration and counters
  logic [RANK_W-1:0]  rank_q;
  logic [SIZE_W-1:0]  extent_q [NUM_SIZE_REGS];
  logic [COORD_W-1:0] pos_q [MAX_AXES];
  logic [HIT_W-1:0]   hits_q;

  coord_beat_t coord_q [$];
  int          mismatch_cnt = 0;
  int          pending_cnt  = 0;

  assign mismatches_o = mismatch_cnt;
  assign pending_o    = pending_cnt;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_cnt++;
  endtask

  // Rank zero behaves as one, anything above the build limit saturates
  function automatic int unsigned active_rank();
    if (rank_q == '0) return 1;
    if (rank_q > MAX_AXES) return MAX_AXES;
    return rank_q;
  endfunction

  // Zero extent behaves as one, oversize extents clip to the coordinate range
  function automatic logic [SIZE_W-1:0] active_extent(input int unsigned ax);
    logic [SIZE_W-1:0] ext;
    ext = (ax < NUM_SIZE_REGS) ? extent_q[ax] : SIZE_W'(1);
    if (ext == '0) ext = SIZE_W'(1);
    if (ext > EXTENT_CAP) ext = EXTENT_CAP;
    return ext;
  endfunction

  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_RANK:       rank_q = data[RANK_W-1:0];
      REG_SIZE_AXIS0: extent_q[0] = data;
      REG_SIZE_AXIS1: extent_q[1] = data;
      REG_SIZE_AXIS2: extent_q[2] = data;
      REG_SIZE_AXIS3: extent_q[3] = data;
      default: ;
    endcase
  endtask

  // Queue the tuple of a true element, then step the counters innermost first
  task automatic predict_tuple(input logic is_true);
    int unsigned       r;
    logic              carry;
    logic [SIZE_W-1:0] lim;
    coord_beat_t       beat;
    r = active_rank();
    if (is_true) begin
      for (int unsigned a = 0; a < r; a++) begin
        beat.coord = pos_q[a];
        beat.axis  = AXIS_W'(a);
        beat.hit   = hits_q;
        beat.last  = (a == r - 1);
        coord_q.push_back(beat);
      end
      hits_q = hits_q + 1'b1;
    end
    carry = 1'b1;
    for (int a = int'(r) - 1; a >= 0; a--) begin
      if (carry) begin
        lim = active_extent(a) - 1'b1;
        if ({1'b0, pos_q[a]} >= lim) begin
          pos_q[a] = '0;
        end else begin
          pos_q[a] = pos_q[a] + 1'b1;
          carry = 1'b0;
        end
      end
    end
    // counters wrapped on every axis: end of tensor
    if (carry) hits_q = '0;
  endtask

  task automatic check_coord();
    coord_beat_t want;
    if (coord_q.size() == 0) begin
      report_mismatch($sformatf("unexpected coordinate %0d axis %0d hit %0d last %0b",
                                coord_i, axis_i, hit_number_i, last_axis_i));
      return;
    end
    want = coord_q.pop_front();
    if (coord_i !== want.coord)
      report_mismatch($sformatf("coord %0d, want %0d (hit %0d axis %0d)",
                                coord_i, want.coord, want.hit, want.axis));
    if (axis_i !== want.axis)
      report_mismatch($sformatf("axis %0d, want %0d (hit %0d)", axis_i, want.axis, want.hit));
    if (hit_number_i !== want.hit)
      report_mismatch($sformatf("hit number %0d, want %0d (axis %0d)",
                                hit_number_i, want.hit, want.axis));
    if (last_axis_i !== want.last)
      report_mismatch($sformatf("last flag %0b, want %0b (hit %0d axis %0d)",
                                last_axis_i, want.last, want.hit, want.axis));
  endtask

  // Compare before predicting, so a tuple never matches in its own cycle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q = RANK_W'(1);
      for (int a = 0; a < NUM_SIZE_REGS; a++) extent_q[a] = SIZE_W'(1);
      for (int a = 0; a < MAX_AXES; a++) pos_q[a] = '0;
      hits_q = '0;
      coord_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) check_coord();
      if (cfg_valid_i && cfg_ready_i) apply_write(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_i) predict_tuple(mask_bit_i);
    end
    pending_cnt = coord_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import nce_pkg::*;

  localparam int unsigned          STALL_LIMIT   = 4000;
  localparam int unsigned          SETTLE_CYCLES = 8;
  localparam int unsigned          BLOCK_ITEMS   = 50;
  localparam logic [CFG_DATA_W-1:0] FULL_EXTENT  = 1 << COORD_BITS_DEF;
  localparam logic [CFG_DATA_W-1:0] ALL_ONES     = '1;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = REG_RANK;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic                  mask_bit_i  = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [COORD_W-1:0]    coord_o;
  logic [AXIS_W-1:0]     axis_o;
  logic [HIT_W-1:0]      hit_number_o;
  logic                  last_axis_o;

  int          fail_count;
  int          pending_cnt;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned quiet_cycles  = 0;

  nonzero_coordinate_emitter uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mask_bit_i   (mask_bit_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .coord_o      (coord_o),
    .axis_o       (axis_o),
    .hit_number_o (hit_number_o),
    .last_axis_o  (last_axis_o)
  );

  nce_checker coord_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .mask_bit_i   (mask_bit_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .coord_i      (coord_o),
    .axis_i       (axis_o),
    .hit_number_i (hit_number_o),
    .last_axis_i  (last_axis_o),
    .mismatches_o (fail_count),
    .pending_o    (pending_cnt)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Receiver back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: too long without any transaction on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a clock edge; returns at the edge where the element is taken
  task automatic send_mask(input logic is_true);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mask_bit_i <= is_true;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic pause_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait for every outstanding coordinate, then let trailing false elements settle
  task automatic wait_drained();
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic finish_cfg();
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_config(input logic [CFG_DATA_W-1:0] rank, input logic [CFG_DATA_W-1:0] ext0,
                             input logic [CFG_DATA_W-1:0] ext1, input logic [CFG_DATA_W-1:0] ext2,
                             input logic [CFG_DATA_W-1:0] ext3);
    write_reg(REG_RANK, rank);
    write_reg(REG_SIZE_AXIS0, ext0);
    write_reg(REG_SIZE_AXIS1, ext1);
    write_reg(REG_SIZE_AXIS2, ext2);
    write_reg(REG_SIZE_AXIS3, ext3);
    finish_cfg();
  endtask

  // Mostly legal ranks, now and then zero or above the limit
  function automatic logic [CFG_DATA_W-1:0] pick_rank();
    if ($urandom_range(99) < 85) return CFG_DATA_W'($urandom_range(1, MAX_RANK_DEF));
    return CFG_DATA_W'($urandom_range(5, 8) % 8);
  endfunction

  // Mostly small extents so tensors wrap often, sometimes the edge values
  function automatic logic [CFG_DATA_W-1:0] pick_extent();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 6) return '0;
    if (roll < 10) return FULL_EXTENT;
    if (roll < 13) return ALL_ONES;
    return CFG_DATA_W'($urandom_range(1, 4));
  endfunction

  // One block of random mask density, with one full drain somewhere inside
  task automatic run_block(input int unsigned n_items);
    int unsigned density;
    int unsigned hold_at;
    density = $urandom_range(5, 95);
    hold_at = $urandom_range(1, n_items - 1);
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i == hold_at) begin
        pause_input();
        wait_drained();
      end
      send_mask($urandom_range(99) < density);
    end
    pause_input();
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 26;
    recv_idle_pct = 74;

    // Reset config: every element is a whole tensor
    send_mask(1'b1);
    send_mask(1'b1);
    send_mask(1'b0);
    send_mask(1'b1);
    pause_input();
    wait_drained();

    // Full rank with a unit axis in the middle
    load_config(4, 2, 1, 3, 2);
    for (int i = 0; i < 8; i++) send_mask(i % 3 != 1);
    pause_input();
    wait_drained();

    // Rank zero and extent zero both act as one
    load_config(0, 0, 5, 5, 5);
    send_mask(1'b1);
    send_mask(1'b1);
    pause_input();
    wait_drained();

    // Rank above the limit, oversize and zero extents
    load_config(7, ALL_ONES, 2, 0, 3);
    for (int i = 0; i < 4; i++) send_mask(1'b1);
    pause_input();
    wait_drained();

    // Writes to unmapped indexes change nothing
    for (int idx = REG_SIZE_AXIS3 + 1; idx < (1 << CFG_IDX_W); idx++)
      write_reg(CFG_IDX_W'(idx), ALL_ONES);
    write_reg(CFG_IDX_W'((1 << CFG_IDX_W) - 1), '0);
    finish_cfg();
    send_mask(1'b1);
    send_mask(1'b1);
    pause_input();
    wait_drained();

    load_config(2, FULL_EXTENT, 3, 1, 1);
    for (int i = 0; i < 3; i++) send_mask(1'b1);
    pause_input();
    wait_drained();

    // Random blocks under three back-pressure profiles
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 74;
        end
        1: begin
          send_idle_pct = 74;
          recv_idle_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int blk = 0; blk < 3; blk++) begin
        load_config(pick_rank(), pick_extent(), pick_extent(), pick_extent(), pick_extent());
        run_block(BLOCK_ITEMS);
      end
    end

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
